FILE: sv/ffea_pkg.sv
// shared types and constants of the free extent allocator
`default_nettype none
package ffea_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic FUNC_FREE  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_END,
        S_ALLOC_END,
        S_CP_RD,
        S_CP_WR,
        S_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_SCAN_RD,
        OP_FREE_CHK,
        OP_ALLOC_CHK,
        OP_ALLOC_WR,
        OP_DROP_SETUP,
        OP_MERGE_WR,
        OP_INS_SETUP,
        OP_CP_RD,
        OP_CP_WR,
        OP_CP_FINISH,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       st_we;
        logic [1:0] st;
    } ctrl_t;

    typedef struct packed {
        logic is_free;
        logic len_zero;
        logic scan_end;
        logic chk_stop;
        logic fit;
        logic exact;
        logic hits_zero;
        logic full;
        logic cp_done;
    } flags_t;

endpackage
`default_nettype wire

FILE: sv/ffea_ctrl.sv
// controller state machine of the free extent allocator
`default_nettype none
module ffea_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire ffea_pkg::flags_t flags,
    output ffea_pkg::ctrl_t      ctrl
);

    ffea_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic fin_go;

    assign fin_go = (state_reg == ffea_pkg::S_FIN) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffea_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (fin_go)
            out_valid_next = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffea_pkg::S_IDLE:
                if (in_valid)
                    state_next = ffea_pkg::S_PREP;
            ffea_pkg::S_PREP:
                state_next = flags.len_zero ? ffea_pkg::S_FIN : ffea_pkg::S_SCAN_RD;
            ffea_pkg::S_SCAN_RD:
                if (flags.scan_end)
                    state_next = flags.is_free ? ffea_pkg::S_FREE_END : ffea_pkg::S_FIN;
                else
                    state_next = ffea_pkg::S_SCAN_CHK;
            ffea_pkg::S_SCAN_CHK:
                if (flags.is_free)
                    state_next = flags.chk_stop ? ffea_pkg::S_FREE_END : ffea_pkg::S_SCAN_RD;
                else
                    state_next = flags.fit ? ffea_pkg::S_ALLOC_END : ffea_pkg::S_SCAN_RD;
            ffea_pkg::S_FREE_END:
                if (flags.hits_zero && flags.full)
                    state_next = ffea_pkg::S_FIN;
                else
                    state_next = ffea_pkg::S_CP_RD;
            ffea_pkg::S_ALLOC_END:
                state_next = flags.exact ? ffea_pkg::S_CP_RD : ffea_pkg::S_FIN;
            ffea_pkg::S_CP_RD:
                state_next = flags.cp_done ? ffea_pkg::S_FIN : ffea_pkg::S_CP_WR;
            ffea_pkg::S_CP_WR:
                state_next = ffea_pkg::S_CP_RD;
            ffea_pkg::S_FIN:
                if (fin_go)
                    state_next = ffea_pkg::S_IDLE;
            default:
                state_next = ffea_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.op    = ffea_pkg::OP_NONE;
        ctrl.st_we = 1'b0;
        ctrl.st    = ffea_pkg::ST_OK;
        in_ready   = 1'b0;
        case (state_reg)
            ffea_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctrl.op = ffea_pkg::OP_LOAD;
            end
            ffea_pkg::S_PREP:
            begin
                ctrl.op = ffea_pkg::OP_PREP;
                if (flags.len_zero)
                begin
                    ctrl.st_we = 1'b1;
                    ctrl.st    = ffea_pkg::ST_ZERO;
                end
            end
            ffea_pkg::S_SCAN_RD:
                if (!flags.scan_end)
                    ctrl.op = ffea_pkg::OP_SCAN_RD;
                else if (!flags.is_free)
                begin
                    ctrl.st_we = 1'b1;
                    ctrl.st    = ffea_pkg::ST_NOFIT;
                end
            ffea_pkg::S_SCAN_CHK:
                if (flags.is_free)
                begin
                    if (!flags.chk_stop)
                        ctrl.op = ffea_pkg::OP_FREE_CHK;
                end
                else
                    ctrl.op = ffea_pkg::OP_ALLOC_CHK;
            ffea_pkg::S_FREE_END:
                if (!flags.hits_zero)
                    ctrl.op = ffea_pkg::OP_MERGE_WR;
                else if (flags.full)
                begin
                    ctrl.st_we = 1'b1;
                    ctrl.st    = ffea_pkg::ST_FULL;
                end
                else
                    ctrl.op = ffea_pkg::OP_INS_SETUP;
            ffea_pkg::S_ALLOC_END:
                ctrl.op = flags.exact ? ffea_pkg::OP_DROP_SETUP : ffea_pkg::OP_ALLOC_WR;
            ffea_pkg::S_CP_RD:
                ctrl.op = flags.cp_done ? ffea_pkg::OP_CP_FINISH : ffea_pkg::OP_CP_RD;
            ffea_pkg::S_CP_WR:
                ctrl.op = ffea_pkg::OP_CP_WR;
            ffea_pkg::S_FIN:
                if (fin_go)
                    ctrl.op = ffea_pkg::OP_FIN;
            default:
                ctrl.op = ffea_pkg::OP_NONE;
        endcase
    end

    assign out_valid = out_valid_reg;

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ffea_pkg::S_PREP))
        else $error("accepted transaction did not start processing");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffea_pkg::S_FIN && out_valid_reg && !out_ready)
        |=> (state_reg == ffea_pkg::S_FIN))
        else $error("result overwrote an untaken result");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffea_pkg::S_CP_WR) |-> ($past(state_reg) == ffea_pkg::S_CP_RD))
        else $error("copy write without read");

    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> out_valid_reg)
        else $error("finished result not presented");

endmodule
`default_nettype wire

FILE: sv/ffea_dp.sv
// datapath and extent table of the free extent allocator
`default_nettype none
module ffea_dp #(
    parameter int MAX_EXTENTS = 64,
    parameter int BLOCK_BITS  = 48
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             func,
    input  wire logic [47:0]      start_block,
    input  wire logic [47:0]      block_count,
    input  wire ffea_pkg::ctrl_t  ctrl,
    output ffea_pkg::flags_t      flags,
    output logic [47:0]           granted_start,
    output logic [1:0]            status,
    output logic [6:0]            extents_held
);

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int AW = $clog2(MAX_EXTENTS);
    localparam logic [BLOCK_BITS-1:0] MASK = {BLOCK_BITS{1'b1}};

    logic [BLOCK_BITS-1:0] mem_start [MAX_EXTENTS];
    logic [BLOCK_BITS-1:0] mem_len   [MAX_EXTENTS];

    logic                  func_reg;
    logic [BLOCK_BITS-1:0] s_reg, len_reg, e_reg, granted_reg;
    logic [BLOCK_BITS-1:0] rd_a_reg, rd_l_reg;
    logic [CW-1:0]         idx_reg, first_reg, hits_reg, count_reg;
    logic [CW-1:0]         src_reg, dst_reg, drop_reg;
    logic                  up_reg;
    logic [1:0]            st_reg;
    logic [47:0]           out_granted_reg;
    logic [1:0]            out_status_reg;
    logic [6:0]            out_held_reg;

    logic [63:0]           start_wide, count_wide, granted_wide, held_wide;
    logic [BLOCK_BITS-1:0] room, clip, b_end;
    logic                  rd_en, wr_en, hit;
    logic [CW-1:0]         rd_idx, wr_idx;
    logic [BLOCK_BITS-1:0] wr_s, wr_l;

    assign start_wide   = {16'd0, start_block};
    assign count_wide   = {16'd0, block_count};
    assign granted_wide = 64'(granted_reg);
    assign held_wide    = 64'(count_reg);

    assign room  = MASK - s_reg;
    assign clip  = (func_reg == ffea_pkg::FUNC_FREE && len_reg > room) ? room : len_reg;
    assign b_end = rd_a_reg + rd_l_reg;
    assign hit   = b_end >= s_reg;

    always_comb
    begin
        flags.is_free   = (func_reg == ffea_pkg::FUNC_FREE);
        flags.len_zero  = (clip == '0);
        flags.scan_end  = (idx_reg == count_reg);
        flags.chk_stop  = (rd_a_reg > e_reg);
        flags.fit       = (rd_l_reg >= len_reg);
        flags.exact     = (rd_l_reg == len_reg);
        flags.hits_zero = (hits_reg == '0);
        flags.full      = (count_reg >= CW'(MAX_EXTENTS));
        flags.cp_done   = up_reg ? (dst_reg <= idx_reg) : (src_reg >= count_reg);
    end

    // table port selection
    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = idx_reg;
        wr_en  = 1'b0;
        wr_idx = idx_reg;
        wr_s   = s_reg;
        wr_l   = e_reg - s_reg;
        case (ctrl.op)
            ffea_pkg::OP_SCAN_RD:
                rd_en = 1'b1;
            ffea_pkg::OP_CP_RD:
            begin
                rd_en  = 1'b1;
                rd_idx = src_reg;
            end
            ffea_pkg::OP_ALLOC_WR:
            begin
                wr_en = 1'b1;
                wr_s  = rd_a_reg + len_reg;
                wr_l  = rd_l_reg - len_reg;
            end
            ffea_pkg::OP_MERGE_WR:
            begin
                wr_en  = 1'b1;
                wr_idx = first_reg;
            end
            ffea_pkg::OP_CP_WR:
            begin
                wr_en  = 1'b1;
                wr_idx = dst_reg;
                wr_s   = rd_a_reg;
                wr_l   = rd_l_reg;
            end
            ffea_pkg::OP_CP_FINISH:
                wr_en = up_reg;
            default:
                wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_idx[AW-1:0]] <= wr_s;
            mem_len[wr_idx[AW-1:0]]   <= wr_l;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_start[rd_idx[AW-1:0]];
            rd_l_reg <= mem_len[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.op == ffea_pkg::OP_CP_FINISH)
        begin
            if (up_reg)
                count_reg <= count_reg + CW'(1);
            else
                count_reg <= count_reg - drop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.st_we)
            st_reg <= ctrl.st;
        case (ctrl.op)
            ffea_pkg::OP_LOAD:
            begin
                func_reg    <= func;
                s_reg       <= start_wide[BLOCK_BITS-1:0];
                len_reg     <= count_wide[BLOCK_BITS-1:0];
                idx_reg     <= '0;
                hits_reg    <= '0;
                granted_reg <= '0;
                st_reg      <= ffea_pkg::ST_OK;
            end
            ffea_pkg::OP_PREP:
            begin
                len_reg <= clip;
                e_reg   <= s_reg + clip;
            end
            ffea_pkg::OP_FREE_CHK:
            begin
                if (hit)
                begin
                    if (hits_reg == '0)
                        first_reg <= idx_reg;
                    hits_reg <= hits_reg + CW'(1);
                    if (rd_a_reg < s_reg)
                        s_reg <= rd_a_reg;
                    if (b_end > e_reg)
                        e_reg <= b_end;
                end
                idx_reg <= idx_reg + CW'(1);
            end
            ffea_pkg::OP_ALLOC_CHK:
                if (flags.fit)
                    granted_reg <= rd_a_reg;
                else
                    idx_reg <= idx_reg + CW'(1);
            ffea_pkg::OP_DROP_SETUP:
            begin
                up_reg   <= 1'b0;
                dst_reg  <= idx_reg;
                src_reg  <= idx_reg + CW'(1);
                drop_reg <= CW'(1);
            end
            ffea_pkg::OP_MERGE_WR:
            begin
                up_reg   <= 1'b0;
                dst_reg  <= first_reg + CW'(1);
                src_reg  <= first_reg + hits_reg;
                drop_reg <= hits_reg - CW'(1);
            end
            ffea_pkg::OP_INS_SETUP:
            begin
                up_reg  <= 1'b1;
                dst_reg <= count_reg;
                src_reg <= count_reg - CW'(1);
            end
            ffea_pkg::OP_CP_WR:
                if (up_reg)
                begin
                    src_reg <= src_reg - CW'(1);
                    dst_reg <= dst_reg - CW'(1);
                end
                else
                begin
                    src_reg <= src_reg + CW'(1);
                    dst_reg <= dst_reg + CW'(1);
                end
            ffea_pkg::OP_FIN:
            begin
                out_granted_reg <= granted_wide[47:0];
                out_status_reg  <= st_reg;
                out_held_reg    <= held_wide[6:0];
            end
            default:
                func_reg <= func_reg;
        endcase
    end

    assign granted_start = out_granted_reg;
    assign status        = out_status_reg;
    assign extents_held  = out_held_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EXTENTS))
        else $error("extent count beyond table depth");

endmodule
`default_nettype wire

FILE: sv/first_fit_free_extent_allocator.sv
// top level of the first-fit free extent allocator
// usage:
//   input channel in_valid/in_ready carries func, start_block, block_count;
//   func 0 frees an extent (merged with every touching free extent),
//   func 1 allocates block_count blocks from the lowest fitting extent.
//   output channel out_valid/out_ready carries granted_start, status and
//   extents_held, one result transaction per request.
// timing: a request scans the table entry by entry and may then move
//   entries to close or open a gap; the single-port extent table, read and
//   written once per entry step, sets the pace. one request at a time.
// reset empties the table at once; no clearing pass is needed.
// a new request is taken while an earlier result still waits; when the
//   receiver stalls, the following request finishes its work and then
//   holds until the output register is free.
`default_nettype none
module first_fit_free_extent_allocator #(
    parameter int MAX_EXTENTS = 64,
    parameter int BLOCK_BITS  = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [47:0] start_block,
    input  wire logic [47:0] block_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [47:0]      granted_start,
    output logic [1:0]       status,
    output logic [6:0]       extents_held
);

    ffea_pkg::ctrl_t  ctrl;
    ffea_pkg::flags_t flags;

    ffea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    ffea_dp #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .start_block   (start_block),
        .block_count   (block_count),
        .ctrl          (ctrl),
        .flags         (flags),
        .granted_start (granted_start),
        .status        (status),
        .extents_held  (extents_held)
    );

endmodule
`default_nettype wire
